[design/ovtb_pkg.sv]
// Shared types and constants for the overwriting event trace buffer.
`default_nettype none

package ovtb_pkg;

    // Field widths fixed by the record format
    localparam int CFG_W  = 5;
    localparam int CMD_W  = 2;
    localparam int SEQ_W  = 64;
    localparam int TS_W   = 64;
    localparam int SEV_W  = 3;
    localparam int SRC_W  = 4;
    localparam int CODE_W = 16;
    localparam int OCC_W  = 5;
    localparam int KIND_W = 2;

    // Capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOG   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SNAP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_LOG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SNAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SNAP
    } state_t;

    // One stored record
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TS_W-1:0]   ts;
        logic [CODE_W-1:0] code;
        logic [SRC_W-1:0]  src;
        logic [SEV_W-1:0]  sev;
    } rec_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              log_en;
        logic              clear_en;
        logic              snap_begin;
        logic              rd_issue;
        logic              rec_load;
        logic              ack_load;
        logic [KIND_W-1:0] ack_kind;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic rd_at_end;
    } dp_status_t;

endpackage

`default_nettype wire

[design/ovtb_ctrl.sv]
// Controller: handshakes, snapshot sequencing and result pipeline valids.
`default_nettype none

module ovtb_ctrl
    import ovtb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CMD_W-1:0] command,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire dp_status_t       status,
    output ctrl_cmd_t             ctl
);

    state_t state_reg;
    state_t state_next;
    logic   rd_valid_reg;
    logic   rd_valid_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   ready_c;

    // Next state, commands and pipeline valids
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ready_c    = 1'b0;
        out_free   = !out_valid_reg || out_ready;

        // Move a fetched record into the output register when it is free
        ctl.rec_load = rd_valid_reg && out_free;

        unique case (state_reg)
            ST_IDLE:
            begin
                ready_c = !rd_valid_reg && out_free;
                if (in_valid && ready_c)
                begin
                    unique case (command)
                        CMD_LOG:
                        begin
                            ctl.log_en   = 1'b1;
                            ctl.ack_load = 1'b1;
                            ctl.ack_kind = KIND_LOG;
                        end
                        CMD_SNAP:
                        begin
                            if (status.fill_zero)
                            begin
                                ctl.ack_load = 1'b1;
                                ctl.ack_kind = KIND_SNAP;
                            end
                            else
                            begin
                                ctl.snap_begin = 1'b1;
                                state_next     = ST_SNAP;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clear_en = 1'b1;
                            ctl.ack_load = 1'b1;
                            ctl.ack_kind = KIND_CLEAR;
                        end
                        default:
                        begin
                            // unused code: take the transfer, no result
                        end
                    endcase
                end
            end
            ST_SNAP:
            begin
                // Issue one read whenever the fetch stage can take it
                if (!rd_valid_reg || ctl.rec_load)
                begin
                    ctl.rd_issue = 1'b1;
                    if (status.rd_at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.rd_issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (ctl.rec_load)
        begin
            rd_valid_next = 1'b0;
        end
        else
        begin
            rd_valid_next = rd_valid_reg;
        end

        if (ctl.ack_load || ctl.rec_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = ready_c;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[design/ovtb_datapath.sv]
// Datapath: record memory, pointers, counters and the result register.
`default_nettype none

module ovtb_datapath
    import ovtb_pkg::*;
#(
    parameter int MAX_RECORDS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic [TS_W-1:0]   event_time,
    input  wire logic [SEV_W-1:0]  severity,
    input  wire logic [SRC_W-1:0]  event_source,
    input  wire logic [CODE_W-1:0] event_code,
    input  wire ctrl_cmd_t         ctl,
    output dp_status_t             status,
    output logic [KIND_W-1:0]      kind,
    output logic [SEQ_W-1:0]       sequence_res,
    output logic [TS_W-1:0]        rec_timestamp,
    output logic [SEV_W-1:0]       rec_severity,
    output logic [SRC_W-1:0]       rec_source,
    output logic [CODE_W-1:0]      rec_code,
    output logic                   record_valid,
    output logic                   last,
    output logic [OCC_W-1:0]       occupancy,
    output logic [SEQ_W-1:0]       dropped_total
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int PTR_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Configuration and bookkeeping
    logic [CFG_W-1:0] cap_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [PTR_W-1:0] start_reg;
    logic [PTR_W-1:0] start_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic [SEQ_W-1:0] drop_reg;
    logic [SEQ_W-1:0] drop_next;

    // Snapshot read-out
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] rd_cnt_next;
    rec_t             rd_data_reg;
    logic             rd_last_reg;

    // Result register
    logic [KIND_W-1:0] kind_reg;
    logic [SEQ_W-1:0]  seq_res_reg;
    logic [TS_W-1:0]   rec_ts_reg;
    logic [SEV_W-1:0]  rec_sev_reg;
    logic [SRC_W-1:0]  rec_src_reg;
    logic [CODE_W-1:0] rec_code_reg;
    logic              rec_valid_reg;
    logic              last_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [SEQ_W-1:0]  dropped_reg;

    // Record store
    rec_t             mem [MAX_RECORDS];

    logic [CMP_W-1:0] cap_wide;
    logic [CNT_W-1:0] cap_now;
    logic             cap_zero;
    logic             do_log;
    logic             fill_lt_cap;
    logic [PTR_W-1:0] slot;
    rec_t             wr_rec;

    // Clamp the capacity to the store depth
    always_comb
    begin
        cap_wide = (CMP_W'(cap_reg) > CMP_W'(MAX_RECORDS)) ? CMP_W'(MAX_RECORDS)
                                                           : CMP_W'(cap_reg);
        cap_now  = CNT_W'(cap_wide);
        cap_zero = (cap_now == '0);
    end

    // Log slot choice and next bookkeeping values
    always_comb
    begin
        do_log      = ctl.log_en && !cap_zero;
        fill_lt_cap = (fill_reg < cap_now);
        slot        = fill_lt_cap ? fill_reg[PTR_W-1:0] : start_reg;

        fill_next  = fill_reg;
        start_next = start_reg;
        seq_next   = seq_reg;
        drop_next  = drop_reg;

        if (cfg_we)
        begin
            fill_next  = '0;
            start_next = '0;
        end
        else if (ctl.clear_en)
        begin
            fill_next  = '0;
            start_next = '0;
            drop_next  = '0;
        end
        else if (do_log)
        begin
            seq_next = seq_reg + SEQ_W'(1);
            if (fill_lt_cap)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            else
            begin
                // overwrite the oldest record and advance the start
                drop_next = drop_reg + SEQ_W'(1);
                if (CNT_W'(start_reg) + CNT_W'(1) == cap_now)
                begin
                    start_next = '0;
                end
                else
                begin
                    start_next = start_reg + PTR_W'(1);
                end
            end
        end

        wr_rec.seq  = seq_reg;
        wr_rec.ts   = event_time;
        wr_rec.code = event_code;
        wr_rec.src  = event_source;
        wr_rec.sev  = severity;
    end

    // Snapshot walk from the oldest record
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        rd_cnt_next = rd_cnt_reg;
        if (ctl.snap_begin)
        begin
            rd_ptr_next = start_reg;
            rd_cnt_next = '0;
        end
        else if (ctl.rd_issue)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
            if (CNT_W'(rd_ptr_reg) + CNT_W'(1) == fill_reg)
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            end
        end

        status.fill_zero = (fill_reg == '0);
        status.rd_at_end = (rd_cnt_reg + CNT_W'(1) == fill_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            fill_reg   <= '0;
            start_reg  <= '0;
            seq_reg    <= SEQ_W'(1);
            drop_reg   <= '0;
            rd_ptr_reg <= '0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            fill_reg   <= fill_next;
            start_reg  <= start_next;
            seq_reg    <= seq_next;
            drop_reg   <= drop_next;
            rd_ptr_reg <= rd_ptr_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    // Record memory write port
    always_ff @(posedge clk)
    begin
        if (do_log)
        begin
            mem[slot] <= wr_rec;
        end
    end

    // Record memory read port, registered
    always_ff @(posedge clk)
    begin
        if (ctl.rd_issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
            rd_last_reg <= status.rd_at_end;
        end
    end

    // Result register: acknowledges or fetched records
    always_ff @(posedge clk)
    begin
        if (ctl.ack_load)
        begin
            kind_reg      <= ctl.ack_kind;
            seq_res_reg   <= do_log ? seq_reg : '0;
            rec_ts_reg    <= '0;
            rec_sev_reg   <= '0;
            rec_src_reg   <= '0;
            rec_code_reg  <= '0;
            rec_valid_reg <= 1'b0;
            last_reg      <= 1'b1;
            occ_reg       <= OCC_W'(fill_next);
            dropped_reg   <= drop_next;
        end
        else if (ctl.rec_load)
        begin
            kind_reg      <= KIND_SNAP;
            seq_res_reg   <= rd_data_reg.seq;
            rec_ts_reg    <= rd_data_reg.ts;
            rec_sev_reg   <= rd_data_reg.sev;
            rec_src_reg   <= rd_data_reg.src;
            rec_code_reg  <= rd_data_reg.code;
            rec_valid_reg <= 1'b1;
            last_reg      <= rd_last_reg;
            occ_reg       <= OCC_W'(fill_reg);
            dropped_reg   <= drop_reg;
        end
    end

    assign kind          = kind_reg;
    assign sequence_res  = seq_res_reg;
    assign rec_timestamp = rec_ts_reg;
    assign rec_severity  = rec_sev_reg;
    assign rec_source    = rec_src_reg;
    assign rec_code      = rec_code_reg;
    assign record_valid  = rec_valid_reg;
    assign last          = last_reg;
    assign occupancy     = occ_reg;
    assign dropped_total = dropped_reg;

endmodule

`default_nettype wire

[design/overwriting_event_trace_buffer.sv]
// Top level of the overwriting event trace buffer.
//
//   channel  signals                                     transfer when
//   -------  ------------------------------------------  -------------------------
//   input    in_valid/in_ready, command, event_time,      in_valid & in_ready
//            severity, event_source, event_code
//   output   out_valid/out_ready, kind .. dropped_total   out_valid & out_ready
//   config   cfg_we, cfg_wdata (capacity_in_use)          cfg_we
//
// Log, clear and empty snapshots can follow one another every cycle while results
// drain. A snapshot of N records sets the read address, does a registered memory
// read and moves its first record to the output register, then one per cycle while
// the output is free; the next item is taken once the last record has left the
// read register. Reset empties the store, sets the capacity to 16 and the sequence
// to one. A stalled output holds its result and back-pressures the walk and input.
`default_nettype none

module overwriting_event_trace_buffer
    import ovtb_pkg::*;
#(
    parameter int MAX_RECORDS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [TS_W-1:0]   event_time,
    input  wire logic [SEV_W-1:0]  severity,
    input  wire logic [SRC_W-1:0]  event_source,
    input  wire logic [CODE_W-1:0] event_code,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [KIND_W-1:0]      kind,
    output logic [SEQ_W-1:0]       sequence_res,
    output logic [TS_W-1:0]        rec_timestamp,
    output logic [SEV_W-1:0]       rec_severity,
    output logic [SRC_W-1:0]       rec_source,
    output logic [CODE_W-1:0]      rec_code,
    output logic                   record_valid,
    output logic                   last,
    output logic [OCC_W-1:0]       occupancy,
    output logic [SEQ_W-1:0]       dropped_total
);

    ctrl_cmd_t  ctl;
    dp_status_t status;

    // Sequencing and handshakes
    ovtb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctl       (ctl)
    );

    // Storage and result formation
    ovtb_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .event_time    (event_time),
        .severity      (severity),
        .event_source  (event_source),
        .event_code    (event_code),
        .ctl           (ctl),
        .status        (status),
        .kind          (kind),
        .sequence_res  (sequence_res),
        .rec_timestamp (rec_timestamp),
        .rec_severity  (rec_severity),
        .rec_source    (rec_source),
        .rec_code      (rec_code),
        .record_valid  (record_valid),
        .last          (last),
        .occupancy     (occupancy),
        .dropped_total (dropped_total)
    );

endmodule

`default_nettype wire
